// File: rtl/core/compacting_value_list_assert.svh
// Assertion macros for the compacting value list, empty in synthesis.
`ifndef COMPACTING_VALUE_LIST_ASSERT_SVH
`define COMPACTING_VALUE_LIST_ASSERT_SVH

`ifndef SYNTHESIS
`define CVL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CVL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CVL_ASSERT(lbl, prop, msg)
`define CVL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/core/cvl_pkg.sv
// Shared types and constants of the compacting value list.
`default_nettype none

package cvl_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int ACTION_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_FIND    = 2'd3
  } cvl_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } cvl_status_e;

  // Per-cell update control
  typedef struct packed {
    logic load;   // take the load word
    logic shift;  // take the right neighbor's word
  } cvl_cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/cvl_cell.sv
// One storage cell of the list: holds a word, compares it, shifts it down.
`default_nettype none

module cvl_cell
  import cvl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cvl_cell_ctrl_t    ctrl_i,
  input  wire logic [DATA_W-1:0] cmp_i,
  input  wire logic [DATA_W-1:0] load_i,
  input  wire logic [DATA_W-1:0] next_i,
  output logic      [DATA_W-1:0] value_o,
  output logic                   eq_o
);

  logic [DATA_W-1:0] value_q;

  // Shift wins: a delete closes the gap from the matching cell upward.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= next_i;
    end else if (ctrl_i.load) begin
      value_q <= load_i;
    end
  end

  assign eq_o    = (value_q == cmp_i);
  assign value_o = value_q;

endmodule

`default_nettype wire

// File: rtl/core/cvl_pick.sv
// Lowest-match selection over the cell match vector.
`default_nettype none

module cvl_pick
  import cvl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic [DEPTH-1:0]                        match_i,
  output logic      [DEPTH-1:0]                        first_o,
  output logic      [DEPTH-1:0]                        from_o,
  output logic      [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] idx_o,
  output logic                                         hit_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] neg;

  // Two's complement isolates the lowest set bit and marks all cells above it.
  assign neg     = ~match_i + DEPTH'(1);
  assign first_o = match_i & neg;
  assign from_o  = match_i | neg;
  assign hit_o   = |match_i;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_o[i]) begin
        idx_o = idx_o | IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/compacting_value_list.sv
// Top level of the compacting value list: request control and the cell chain.
`default_nettype none
`include "compacting_value_list_assert.svh"

// Bounded list of signed 32-bit words kept in insertion order.
// Request channel: drive action_i, key_i and new_value_i with start high;
// the beat is taken at the rising edge where start is high and busy is low.
// Actions: append key, delete first match and close the gap, replace the
// first match with new_value, or find the first match.
// Result channel: status_o, position_o and entry_count_o are shown for one
// cycle with done_o high; the receiver cannot stall, so take them then.
// Timing: the accept edge compares every cell against the key in parallel
// and registers the match vector; busy is high for the next cycle, where
// the lowest match is picked and the cells load or shift; the result is on
// the ports in the cycle after that, while busy is already low again.
// A new request is not taken while the update of the previous one runs;
// busy holds it off until the cell chain has loaded or shifted.
// Reset: the entry count clears and no result is pending; cell contents
// stay undefined, since cells at or beyond the count are never looked at.
// A delete shifts every cell above the match down by one in parallel.

module compacting_value_list
  import cvl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [DATA_W-1:0]   key_i,
  input  wire logic [DATA_W-1:0]   new_value_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [POS_W-1:0]         position_o,
  output logic [COUNT_W-1:0]       entry_count_o
);

  localparam int IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int PosWW  = (IdxW > POS_W) ? IdxW : POS_W;
  localparam int CntWW  = (CntW > COUNT_W) ? CntW : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } cvl_state_e;

  cvl_state_e state_q, state_d;

  logic [CntW-1:0]   count_q, count_d;
  cvl_action_e       act_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] repl_q;
  logic [DEPTH-1:0]  match_q, match_d;

  logic                done_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [COUNT_W-1:0]  cnt_out_q, cnt_out_d;

  logic                 accept;
  logic                 in_apply;
  logic [DEPTH-1:0]     eq;
  logic [DATA_W-1:0]    value [DEPTH];
  cvl_cell_ctrl_t       ctrl  [DEPTH];
  logic [DATA_W-1:0]    load_word;

  logic [DEPTH-1:0] first_oh;
  logic [DEPTH-1:0] from_vec;
  logic [IdxW-1:0]  hit_idx;
  logic             hit;

  logic             full;
  logic             do_append;
  logic             do_delete;
  logic             do_replace;
  logic [IdxW-1:0]  pos_idx;
  logic [PosWW-1:0] pos_wide;
  logic [CntWW-1:0] cnt_wide;

  assign accept   = start && !busy;
  assign busy     = (state_q == S_APPLY);
  assign in_apply = (state_q == S_APPLY);

  // Cell chain: each cell compares against the incoming key and hands its
  // word to the cell below on a delete.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] next_word;
    if (g == DEPTH - 1) begin : g_last
      assign next_word = value[g];
    end else begin : g_mid
      assign next_word = value[g+1];
    end

    cvl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .cmp_i   (key_i),
      .load_i  (load_word),
      .next_i  (next_word),
      .value_o (value[g]),
      .eq_o    (eq[g])
    );

    // Only cells below the count take part in a search.
    assign match_d[g] = eq[g] && (CntW'(g) < count_q);
  end

  cvl_pick #(
    .DEPTH (DEPTH)
  ) u_pick (
    .match_i (match_q),
    .first_o (first_oh),
    .from_o  (from_vec),
    .idx_o   (hit_idx),
    .hit_o   (hit)
  );

  assign full       = (count_q >= CntW'(DEPTH));
  assign do_append  = in_apply && (act_q == ACT_APPEND) && !full;
  assign do_delete  = in_apply && (act_q == ACT_DELETE) && hit;
  assign do_replace = in_apply && (act_q == ACT_REPLACE) && hit;
  assign load_word  = (act_q == ACT_APPEND) ? key_q : repl_q;

  // Drive per-cell control: append fills the cell at the count, replace
  // loads the first match, delete shifts from the first match upward.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].load  = (do_append && (count_q == CntW'(i))) ||
                      (do_replace && first_oh[i]);
      ctrl[i].shift = do_delete && from_vec[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_append) begin
      count_d = count_q + CntW'(1);
    end else if (do_delete) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Build the result beat.
  always_comb begin
    pos_idx = '0;
    if (act_q == ACT_APPEND) begin
      status_d = full ? ST_FULL : ST_DONE;
      if (!full) begin
        pos_idx = IdxW'(count_q);
      end
    end else if (hit) begin
      status_d = ST_DONE;
      pos_idx  = hit_idx;
    end else begin
      status_d = ST_MISSING;
    end
    pos_wide  = PosWW'(pos_idx);
    pos_d     = pos_wide[POS_W-1:0];
    cnt_wide  = CntWW'(count_d);
    cnt_out_d = cnt_wide[COUNT_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= in_apply;
    end
  end

  // Hold the request and its match vector for the update cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= cvl_action_e'(action_i);
      key_q   <= key_i;
      repl_q  <= new_value_i;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_apply) begin
      status_q  <= status_d;
      pos_q     <= pos_d;
      cnt_out_q <= cnt_out_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign entry_count_o = cnt_out_q;

  `CVL_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "entry count above depth")
  `CVL_ASSERT(a_first_onehot, in_apply |-> $onehot0(first_oh), "more than one first match")
  `CVL_ASSERT(a_accept_to_done, accept |-> ##2 done_o, "accepted request lost its result")
  `CVL_ASSERT(a_done_after_apply, done_o |-> $past(in_apply), "result without update cycle")
  `CVL_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o && !busy, "activity during reset")

endmodule

`default_nettype wire
